@@ hdl/lcg_random_source_core_assert.svh @@
// Assertion macros for the LCG random source; empty in synthesis.
`ifndef LCG_RANDOM_SOURCE_CORE_ASSERT_SVH
`define LCG_RANDOM_SOURCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LCG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lcg check failed");
`define LCG_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcg check failed");
`define LCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcg check failed");
`else
`define LCG_ASSERT_ALWAYS(label, cond)
`define LCG_ASSERT_IMPLY(label, ante, cons)
`define LCG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/lcg_pkg.sv @@
// Constants and operation codes for the LCG random source.
package lcg_pkg;

  localparam logic [31:0] LCG_MULT = 32'd1103515245;
  localparam logic [30:0] LCG_INC  = 31'd12345;
  localparam logic [30:0] LCG_MASK = 31'h7FFF_FFFF;

  localparam int VALUE_W = 55;

  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_COMBINE = 2'd1;
  localparam logic [1:0] OP_BOUNDED = 2'd2;

endpackage

@@ hdl/lcg_mul.sv @@
// Shared 32x32 multiplier with registered product.
module lcg_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end

endmodule

@@ hdl/lcg_random_source_core.sv @@
// LCG random source: one shared multiplier under a small sequencer.
// The result register loads after a step multiply and a step add for a raw
// draw, after four such draws on the multiplier for the combined word, after
// one draw, the scaling multiply and two fold steps for /(2^31-1) for a
// bounded draw, and straight from idle for the unused code. The next
// transaction is taken the cycle after; a stalled output holds the finish state.
// Synchronous reset: generator state goes to 1, sequencer idle, no result.
`include "lcg_random_source_core_assert.svh"

module lcg_random_source_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] upper_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [54:0] value
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_STEP_MUL  = 3'd1;
  localparam logic [2:0] ST_STEP_ADD  = 3'd2;
  localparam logic [2:0] ST_SCALE_MUL = 3'd3;
  localparam logic [2:0] ST_FOLD1     = 3'd4;
  localparam logic [2:0] ST_FOLD2     = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0]  st;
  logic [31:0] gen_state;
  logic [1:0]  op_reg;
  logic [31:0] limit_reg;
  logic [1:0]  cnt;
  logic [lcg_pkg::VALUE_W-1:0] acc;
  logic [33:0] fold_x;
  logic [31:0] fold_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic [30:0] draw;
  logic [2:0]  fc;
  logic [31:0] fs;
  logic        fge;
  logic [31:0] quot;

  lcg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    if (st == ST_SCALE_MUL) begin
      mul_a = limit_reg;
      mul_b = {1'b0, gen_state[30:0]};
    end else begin
      mul_a = gen_state;
      mul_b = lcg_pkg::LCG_MULT;
    end
  end

  // low 31 bits of the product plus increment, wrapping mod 2^31
  assign draw = mul_p[30:0] + lcg_pkg::LCG_INC;

  // P = a*2^31 + b = a*M + (a + b) with M = 2^31-1; fold twice then one compare
  assign fc   = fold_x[33:31];
  assign fs   = {1'b0, fold_x[30:0]} + {29'b0, fc};
  assign fge  = (fs >= {1'b0, lcg_pkg::LCG_MASK});
  assign quot = fold_q + {29'b0, fc} + {31'b0, fge};

  assign in_stall = (st != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      gen_state <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && st != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      if (seed_we) begin
        gen_state <= seed_data;
      end
      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            op_reg    <= operation;
            limit_reg <= upper_limit;
            acc       <= '0;
            cnt       <= 2'd0;
            if (operation == lcg_pkg::OP_RAW || operation == lcg_pkg::OP_COMBINE ||
                operation == lcg_pkg::OP_BOUNDED) begin
              st <= ST_STEP_MUL;
            end else begin
              st <= ST_FINISH;
            end
          end
        end
        ST_STEP_MUL: begin
          st <= ST_STEP_ADD;
        end
        ST_STEP_ADD: begin
          gen_state <= {1'b0, draw};
          acc       <= {acc[lcg_pkg::VALUE_W-9:0], 8'b0} ^ {24'b0, draw};
          cnt       <= cnt + 2'd1;
          if (op_reg == lcg_pkg::OP_COMBINE && cnt != 2'd3) begin
            st <= ST_STEP_MUL;
          end else if (op_reg == lcg_pkg::OP_BOUNDED) begin
            st <= ST_SCALE_MUL;
          end else begin
            st <= ST_FINISH;
          end
        end
        ST_SCALE_MUL: begin
          st <= ST_FOLD1;
        end
        ST_FOLD1: begin
          fold_x <= {2'b0, mul_p[62:31]} + {3'b0, mul_p[30:0]};
          fold_q <= mul_p[62:31];
          st     <= ST_FOLD2;
        end
        ST_FOLD2: begin
          acc <= {23'b0, quot};
          st  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            value     <= acc;
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  `LCG_ASSERT_NEXT(a_draw_31bit, st == ST_STEP_ADD, gen_state[31] == 1'b0)
  `LCG_ASSERT_NEXT(a_bounded_le_limit, st == ST_FOLD2, acc <= {23'b0, limit_reg})
  `LCG_ASSERT_IMPLY(a_single_draw, st == ST_STEP_MUL && op_reg != lcg_pkg::OP_COMBINE, cnt == 2'd0)
  `LCG_ASSERT_NEXT(a_no_overwrite, (st == ST_FINISH) && out_valid && out_stall, (st == ST_FINISH) && out_valid)

endmodule
